@@ sv/bts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants, codes and types of the beat tone sequencer.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int SONG_DEPTH = 1024;
  localparam int SONG_SLOTS = 8;
  localparam int ADDR_W     = $clog2(SONG_DEPTH);
  localparam int SLOT_W     = $clog2(SONG_SLOTS);

  localparam logic [15:0] TEMPO_RESET  = 16'd120;
  localparam logic [15:0] PERIOD_NUMER = 16'd60000;
  localparam int          DIV_STEPS    = 16;
  localparam int          DIV_CNT_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_LOAD_ENTRY  = 3'd1,
    CMD_LOAD_HEADER = 3'd2,
    CMD_PLAY        = 3'd3,
    CMD_REPLAY      = 3'd4,
    CMD_PLAY_NOTE   = 3'd5,
    CMD_NOP         = 3'd6
  } bts_cmd_t;

  typedef enum logic [1:0] {
    KIND_NOTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_END_IDLE = 2'd2
  } bts_kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] freq;
    logic [7:0]  beats;
  } bts_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [15:0]       tempo;
    logic [7:0]        repeats;
    logic [7:0]        tail;
  } bts_header_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } bts_div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHANGE,
    S_HDR,
    S_ENT_RD,
    S_ENT,
    S_REP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } bts_state_t;

endpackage

@@ sv/bts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_req_if / bts_rsp_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface bts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [2:0]  song_id;
  logic        use_custom;
  logic [15:0] tempo_bpm;
  logic [7:0]  repeat_count;
  logic [7:0]  tail_beats;
  logic [9:0]  entry_address;
  logic [1:0]  entry_kind;
  logic [15:0] entry_freq;
  logic [7:0]  entry_beats;
  logic [15:0] note_freq;

  modport source (
    output valid, cmd, song_id, use_custom, tempo_bpm, repeat_count, tail_beats,
           entry_address, entry_kind, entry_freq, entry_beats, note_freq,
    input  ready
  );
  modport sink (
    input  valid, cmd, song_id, use_custom, tempo_bpm, repeat_count, tail_beats,
           entry_address, entry_kind, entry_freq, entry_beats, note_freq,
    output ready
  );
  modport monitor (
    input valid, ready, cmd, song_id, use_custom, tempo_bpm, repeat_count,
          tail_beats, entry_address, entry_kind, entry_freq, entry_beats, note_freq
  );
endinterface

interface bts_rsp_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_freq;
  logic        playing;
  logic [2:0]  active_song;
  logic [15:0] beat_period_ms;

  modport source (
    output valid, tone_on, tone_freq, playing, active_song, beat_period_ms,
    input  ready
  );
  modport sink (
    input  valid, tone_on, tone_freq, playing, active_song, beat_period_ms,
    output ready
  );
  modport monitor (
    input valid, ready, tone_on, tone_freq, playing, active_song, beat_period_ms
  );
endinterface

@@ sv/bts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_div
// Restoring divider, one quotient bit per cycle: 60000 / divisor.
// ----------------------------------------------------------------------------
module bts_div
  import bts_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [15:0]   divisor,
  output bts_div_stat_t stat
);

  logic                 active;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          rem;
  logic [15:0]          quo;
  logic [15:0]          dvs;
  logic                 done;
  logic [16:0]          trial;
  logic                 fits;

  assign trial = {rem, quo[15]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == DIV_CNT_W'(1));
      if (start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_W'(DIV_STEPS);
      end else if (active) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= PERIOD_NUMER;
      // zero tempo reads as tempo one
      dvs <= (divisor == 16'd0) ? 16'd1 : divisor;
    end else if (active) begin
      rem <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quo <= {quo[14:0], fits};
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

@@ sv/beat_tone_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beat_tone_sequencer_core
// Buzzer melody sequencer: song store, header table, beat stepping and
// beat period divider under one control sequencer.
// Sequence: a tick steps through S_CHANGE, S_HDR and S_ENT_RD, adding S_ENT
//   when it reads an entry and S_REP when the song repeats; then every item
//   runs the 16-step serial divider (S_DIV_GO, S_DIV_WAIT) and its result is
//   registered in S_OUT.
// Throughput: one item at a time; ready is high only when idle, so the next
//   item enters after the previous result is registered, later while a stalled
//   result holds the result register.
// Reset: synchronous; control state clears, tempo 120; memories unset.
// ----------------------------------------------------------------------------
module beat_tone_sequencer_core
  import bts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  bts_req_if.sink   req,
  bts_rsp_if.source rsp
);

  bts_state_t state, state_next;

  logic [2:0]        cur_song;
  logic [2:0]        req_song;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] hstart;
  logic [7:0]        beats_left;
  logic [7:0]        reps_left;
  logic [7:0]        tail_left;
  logic [15:0]       tempo;
  logic              custom;
  logic              playing;
  logic              tone_on;
  logic [15:0]       tone_freq;
  logic              changed;
  logic              out_valid;

  logic              accept;
  logic              ent_we;
  logic              hdr_we;
  logic [ADDR_W-1:0] ent_raddr;
  logic              div_start;
  bts_entry_t        ent_wdata, ent_rdata;
  bts_header_t       hdr_wdata, hdr_rdata;
  bts_div_stat_t     div_stat;
  logic [15:0]       period;

  assign accept = req.valid && req.ready;

  assign ent_wdata.kind  = req.entry_kind;
  assign ent_wdata.freq  = req.entry_freq;
  assign ent_wdata.beats = req.entry_beats;

  assign hdr_wdata.start   = ADDR_W'(req.entry_address);
  assign hdr_wdata.tempo   = req.tempo_bpm;
  assign hdr_wdata.repeats = req.repeat_count;
  assign hdr_wdata.tail    = req.tail_beats;

  bts_ram #(.WIDTH($bits(bts_entry_t)), .DEPTH(SONG_DEPTH)) u_song_mem (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ADDR_W'(req.entry_address)),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  bts_ram #(.WIDTH($bits(bts_header_t)), .DEPTH(SONG_SLOTS)) u_hdr_mem (
    .clk  (clk),
    .we   (hdr_we),
    .waddr(SLOT_W'(req.song_id)),
    .wdata(hdr_wdata),
    .raddr(SLOT_W'(req_song)),
    .rdata(hdr_rdata)
  );

  bts_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .divisor(tempo),
    .stat   (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (bts_cmd_t'(req.cmd) == CMD_TICK) ? S_CHANGE : S_DIV_GO;
        end
      end
      S_CHANGE: state_next = S_HDR;
      S_HDR:    state_next = S_ENT_RD;
      S_ENT_RD: begin
        if (cur_song == 3'd0 || beats_left != 8'd0) begin
          state_next = S_DIV_GO;
        end else begin
          state_next = S_ENT;
        end
      end
      S_ENT: begin
        if (ent_rdata.kind != KIND_NOTE && reps_left > 8'd1) begin
          state_next = S_REP;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_REP:      state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: state_next = div_stat.done ? S_OUT : S_DIV_WAIT;
      S_OUT:      state_next = (!out_valid || rsp.ready) ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    ent_we    = 1'b0;
    hdr_we    = 1'b0;
    div_start = 1'b0;
    ent_raddr = rd_ptr;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        ent_we    = accept && (bts_cmd_t'(req.cmd) == CMD_LOAD_ENTRY);
        hdr_we    = accept && (bts_cmd_t'(req.cmd) == CMD_LOAD_HEADER);
      end
      S_ENT:    ent_raddr = hstart;
      S_DIV_GO: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_song   <= '0;
      req_song   <= '0;
      rd_ptr     <= '0;
      hstart     <= '0;
      beats_left <= '0;
      reps_left  <= '0;
      tail_left  <= '0;
      tempo      <= TEMPO_RESET;
      custom     <= 1'b0;
      playing    <= 1'b0;
      tone_on    <= 1'b0;
      tone_freq  <= '0;
      changed    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (bts_cmd_t'(req.cmd))
              CMD_PLAY, CMD_REPLAY: begin
                if (bts_cmd_t'(req.cmd) == CMD_REPLAY) begin
                  cur_song <= '0;
                end
                req_song <= req.song_id;
                custom   <= req.use_custom;
                if (req.use_custom) begin
                  tempo     <= req.tempo_bpm;
                  reps_left <= req.repeat_count;
                  tail_left <= req.tail_beats;
                end
                playing <= 1'b1;
              end
              CMD_PLAY_NOTE: begin
                cur_song  <= '0;
                req_song  <= '0;
                tone_on   <= 1'b1;
                tone_freq <= req.note_freq;
              end
              default: begin
              end
            endcase
          end
        end
        S_CHANGE: begin
          // apply a pending song change
          changed  <= req_song != cur_song;
          cur_song <= req_song;
          if (req_song != cur_song && req_song == 3'd0) begin
            tone_on <= 1'b0;
            playing <= 1'b0;
          end
        end
        S_HDR: begin
          hstart <= hdr_rdata.start;
          if (changed && cur_song != 3'd0) begin
            tone_on    <= 1'b0;
            rd_ptr     <= hdr_rdata.start;
            beats_left <= '0;
            if (!custom) begin
              tempo     <= hdr_rdata.tempo;
              reps_left <= hdr_rdata.repeats;
              tail_left <= hdr_rdata.tail;
            end
            playing <= 1'b1;
          end
        end
        S_ENT_RD: begin
          if (cur_song == 3'd0) begin
            playing <= 1'b0;
          end else if (beats_left != 8'd0) begin
            beats_left <= beats_left - 8'd1;
          end
        end
        S_ENT: begin
          if (ent_rdata.kind == KIND_NOTE) begin
            tone_on    <= 1'b1;
            tone_freq  <= ent_rdata.freq;
            rd_ptr     <= rd_ptr + ADDR_W'(1);
            beats_left <= (ent_rdata.beats == 8'd0) ? 8'd0 : ent_rdata.beats - 8'd1;
          end else if (reps_left > 8'd1) begin
            reps_left <= reps_left - 8'd1;
          end else begin
            tone_on <= 1'b0;
            if (tail_left != 8'd0) begin
              tail_left <= tail_left - 8'd1;
            end else begin
              playing <= 1'b0;
              // end-and-idle marker (and the unused kind) drop to idle
              if (ent_rdata.kind != KIND_END) begin
                req_song <= '0;
                cur_song <= '0;
                custom   <= 1'b0;
              end
            end
          end
        end
        S_REP: begin
          // restart: sound the entry at the start address
          tone_on    <= 1'b1;
          tone_freq  <= ent_rdata.freq;
          rd_ptr     <= hstart + ADDR_W'(1);
          beats_left <= (ent_rdata.beats == 8'd0) ? 8'd0 : ent_rdata.beats - 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || rsp.ready)) begin
      rsp.tone_on        <= tone_on;
      rsp.tone_freq      <= tone_freq;
      rsp.playing        <= playing;
      rsp.active_song    <= cur_song;
      rsp.beat_period_ms <= period;
    end
  end

  assign period    = div_stat.quotient;
  assign rsp.valid = out_valid;

endmodule

@@ sv/bts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks of the beat tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker
  import bts_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_period
);

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_period))
    else $error("result item dropped or changed while stalled");

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

  // a result never follows its item in the next cycle
  a_no_fast_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("result appeared one cycle after accept");

  // beat period never exceeds the numerator
  a_period_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_period <= PERIOD_NUMER)
    else $error("beat period out of range");

endmodule

bind beat_tone_sequencer_core bts_checker u_bts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_period(rsp.beat_period_ms)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for beat_tone_sequencer_core. A directed table runs
// first: reset values, field extremes, every command and the corner cases of
// the song format. Random song bursts follow: load a short song and its
// header, start it, then tick through it with stray commands mixed in. Each
// result is checked field by field against a cycle-free predictor or a
// pinned row. Song reads never hit unwritten memory; a fill load goes first.
// ----------------------------------------------------------------------------
module tb;
  import bts_pkg::*;

  localparam int          ITEM_TARGET = 1100;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_TAIL  = 40;
  localparam int          CYCLE_LIMIT = 800000;
  localparam int          PRINT_CAP   = 100;
  localparam logic [2:0]  CMD_SPARE   = 3'd7;
  localparam logic [1:0]  KIND_SPARE  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  song_id;
    logic        use_custom;
    logic [15:0] tempo_bpm;
    logic [7:0]  repeat_count;
    logic [7:0]  tail_beats;
    logic [9:0]  entry_address;
    logic [1:0]  entry_kind;
    logic [15:0] entry_freq;
    logic [7:0]  entry_beats;
    logic [15:0] note_freq;
  } cmd_item_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        playing;
    logic [2:0]  active_song;
    logic [15:0] beat_period_ms;
  } tone_result_t;

  typedef struct packed {
    logic [2:0]  cur_song;
    logic [2:0]  req_song;
    logic [9:0]  rd_ptr;
    logic [7:0]  beats_left;
    logic [7:0]  reps_left;
    logic [7:0]  tail_left;
    logic [15:0] tempo;
    logic        custom;
    logic        playing;
    logic        tone_on;
    logic [15:0] tone_freq;
  } seq_state_t;

  typedef struct packed {
    cmd_item_t    it;
    logic         pinned;
    tone_result_t want;
  } dir_row_t;

  localparam tone_result_t AT_RESET  = '{1'b0, 16'd0, 1'b0, 3'd0, 16'd500};
  localparam tone_result_t ZERO_NOTE = '{1'b1, 16'd0, 1'b0, 3'd0, 16'd500};

  logic clk = 1'b0;
  logic rst;

  bts_req_if cmd_ch ();
  bts_rsp_if tone_ch ();

  beat_tone_sequencer_core uut (
    .clk (clk),
    .rst (rst),
    .req (cmd_ch),
    .rsp (tone_ch)
  );

  always #4 clk = ~clk;

  // predictor state and the song stores it reads
  seq_state_t   seq;
  bts_entry_t   song_mem [SONG_DEPTH];
  bit           entry_set [SONG_DEPTH];
  bts_header_t  hdr_tab [SONG_SLOTS];
  bit           slot_set [SONG_SLOTS];
  logic         gap_hit;
  logic         gap_hdr;
  logic [9:0]   gap_at;
  logic [2:0]   gap_slot;

  tone_result_t expected_tones [$];
  dir_row_t     plan [26];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int errors;
  int n_checked;
  int items_done;
  int n_fills;
  int n_cmd [8];
  int cycle_count = 0;

  // ---------------------------------------------------------------- predictor

  function automatic void note_entry(logic [9:0] a);
    if (!entry_set[a] && !gap_hit) begin
      gap_hit = 1'b1;
      gap_hdr = 1'b0;
      gap_at  = a;
    end
  endfunction

  function automatic void note_slot(logic [2:0] n);
    if (!slot_set[n] && !gap_hit) begin
      gap_hit  = 1'b1;
      gap_hdr  = 1'b1;
      gap_slot = n;
    end
  endfunction

  function automatic void sound_note(inout seq_state_t s, input logic [9:0] a);
    note_entry(a);
    s.tone_on    = 1'b1;
    s.tone_freq  = song_mem[a].freq;
    s.rd_ptr     = a + 10'd1;
    s.beats_left = (song_mem[a].beats == 8'd0) ? 8'd0 : song_mem[a].beats - 8'd1;
  endfunction

  function automatic void switch_song(inout seq_state_t s);
    bts_header_t h;
    if (s.req_song != s.cur_song) begin
      s.cur_song = s.req_song;
      s.tone_on  = 1'b0;
      if (s.cur_song == 3'd0) begin
        s.playing = 1'b0;
      end else begin
        note_slot(s.cur_song);
        h            = hdr_tab[s.cur_song % SONG_SLOTS];
        s.rd_ptr     = h.start;
        s.beats_left = 8'd0;
        if (!s.custom) begin
          s.tempo     = h.tempo;
          s.reps_left = h.repeats;
          s.tail_left = h.tail;
        end
        s.playing = 1'b1;
      end
    end
  endfunction

  function automatic tone_result_t tone_predict(inout seq_state_t s, input cmd_item_t it);
    tone_result_t r;
    bts_header_t  h;
    bts_entry_t   e;
    case (it.cmd)
      CMD_TICK: begin
        switch_song(s);
        if (s.cur_song == 3'd0) begin
          s.playing = 1'b0;
        end else begin
          note_slot(s.cur_song);
          note_entry(s.rd_ptr);
          h = hdr_tab[s.cur_song % SONG_SLOTS];
          e = song_mem[s.rd_ptr];
          if (s.beats_left != 8'd0) begin
            s.beats_left = s.beats_left - 8'd1;
          end else if (e.kind == KIND_NOTE) begin
            sound_note(s, s.rd_ptr);
          end else if (s.reps_left > 8'd1) begin
            // an empty song still sounds its first entry on a repeat
            s.reps_left = s.reps_left - 8'd1;
            sound_note(s, h.start);
          end else begin
            s.tone_on = 1'b0;
            if (s.tail_left != 8'd0) begin
              s.tail_left = s.tail_left - 8'd1;
            end else begin
              s.playing = 1'b0;
              if (e.kind >= KIND_END_IDLE) begin
                s.req_song = 3'd0;
                s.custom   = 1'b0;
                s.playing  = 1'b1;
                switch_song(s);
              end
            end
          end
        end
      end
      CMD_LOAD_ENTRY: begin
        song_mem[it.entry_address]  = '{it.entry_kind, it.entry_freq, it.entry_beats};
        entry_set[it.entry_address] = 1'b1;
      end
      CMD_LOAD_HEADER: begin
        hdr_tab[it.song_id]  = '{it.entry_address, it.tempo_bpm, it.repeat_count,
                                 it.tail_beats};
        slot_set[it.song_id] = 1'b1;
      end
      CMD_PLAY, CMD_REPLAY: begin
        if (it.cmd == CMD_REPLAY) s.cur_song = 3'd0;
        s.req_song = it.song_id;
        s.custom   = it.use_custom;
        if (it.use_custom) begin
          s.tempo     = it.tempo_bpm;
          s.reps_left = it.repeat_count;
          s.tail_left = it.tail_beats;
        end
        s.playing = 1'b1;
      end
      CMD_PLAY_NOTE: begin
        s.cur_song  = 3'd0;
        s.req_song  = 3'd0;
        s.tone_on   = 1'b1;
        s.tone_freq = it.note_freq;
      end
      default: ;
    endcase
    r.tone_on        = s.tone_on;
    r.tone_freq      = s.tone_freq;
    r.playing        = s.playing;
    r.active_song    = s.cur_song;
    r.beat_period_ms = (s.tempo == 16'd0) ? PERIOD_NUMER
                                          : 16'(32'(PERIOD_NUMER) / 32'(s.tempo));
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    it.cmd           = 3'($urandom);
    it.song_id       = 3'($urandom);
    it.use_custom    = 1'($urandom);
    it.tempo_bpm     = 16'($urandom);
    it.repeat_count  = 8'($urandom);
    it.tail_beats    = 8'($urandom);
    it.entry_address = 10'($urandom);
    it.entry_kind    = 2'($urandom);
    it.entry_freq    = 16'($urandom);
    it.entry_beats   = 8'($urandom);
    it.note_freq     = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_tempo();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(1, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_beats();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(0, 3));
    if (r < 97) return 8'($urandom_range(4, 12));
    return 8'($urandom);
  endfunction

  function automatic dir_row_t op(logic [2:0] cmd, logic [2:0] id, logic custom,
                                  logic [15:0] tempo, logic [7:0] reps, logic [7:0] tail,
                                  logic [9:0] addr, logic [1:0] kind, logic [15:0] freq,
                                  logic [7:0] beats, logic [15:0] nfreq);
    dir_row_t r;
    r.it     = '{cmd, id, custom, tempo, reps, tail, addr, kind, freq, beats, nfreq};
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t pin(dir_row_t r, tone_result_t w);
    r.pinned = 1'b1;
    r.want   = w;
    return r;
  endfunction

  task automatic drive(cmd_item_t it, logic pinned, tone_result_t want);
    tone_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.cmd           <= it.cmd;
    cmd_ch.song_id       <= it.song_id;
    cmd_ch.use_custom    <= it.use_custom;
    cmd_ch.tempo_bpm     <= it.tempo_bpm;
    cmd_ch.repeat_count  <= it.repeat_count;
    cmd_ch.tail_beats    <= it.tail_beats;
    cmd_ch.entry_address <= it.entry_address;
    cmd_ch.entry_kind    <= it.entry_kind;
    cmd_ch.entry_freq    <= it.entry_freq;
    cmd_ch.entry_beats   <= it.entry_beats;
    cmd_ch.note_freq     <= it.note_freq;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pred = tone_predict(seq, it);
    expected_tones.push_back(pinned ? want : pred);
    n_cmd[it.cmd]++;
    if (it.cmd != CMD_NOP && it.cmd != CMD_SPARE) items_done++;
  endtask

  // Before a tick, try it on a copy of the state; load any entry or header
  // it would read that was never written, then send the tick itself.
  task automatic issue(cmd_item_t it, logic pinned, tone_result_t want);
    seq_state_t trial;
    cmd_item_t  fill;
    if (it.cmd == CMD_TICK) begin
      forever begin
        trial   = seq;
        gap_hit = 1'b0;
        void'(tone_predict(trial, it));
        if (!gap_hit) break;
        fill = rand_item();
        if (gap_hdr) begin
          fill.cmd          = CMD_LOAD_HEADER;
          fill.song_id      = gap_slot;
          fill.tempo_bpm    = pick_tempo();
          fill.repeat_count = 8'($urandom_range(0, 3));
          fill.tail_beats   = 8'($urandom_range(0, 3));
        end else begin
          fill.cmd           = CMD_LOAD_ENTRY;
          fill.entry_address = gap_at;
          fill.entry_beats   = pick_beats();
          if ($urandom_range(0, 1) == 0) fill.entry_kind = KIND_NOTE;
        end
        drive(fill, 1'b0, '0);
        n_fills++;
      end
    end
    drive(it, pinned, want);
  endtask

  task automatic play_song_burst();
    cmd_item_t  it;
    logic [2:0] slot;
    logic [9:0] base;
    int         len;
    slot = 3'($urandom_range(1, 7));
    base = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1016, 1023)) : 10'($urandom);
    len  = $urandom_range(1, 5);
    for (int i = 0; i <= len; i++) begin
      it               = rand_item();
      it.cmd           = CMD_LOAD_ENTRY;
      it.entry_address = base + 10'(i);
      it.entry_kind    = (i < len) ? KIND_NOTE : 2'($urandom_range(1, 3));
      it.entry_beats   = pick_beats();
      issue(it, 1'b0, '0);
    end
    it               = rand_item();
    it.cmd           = CMD_LOAD_HEADER;
    it.song_id       = slot;
    it.entry_address = base;
    it.tempo_bpm     = pick_tempo();
    it.repeat_count  = 8'($urandom_range(0, 3));
    it.tail_beats    = 8'($urandom_range(0, 3));
    issue(it, 1'b0, '0);
    it            = rand_item();
    it.cmd        = ($urandom_range(0, 3) == 0) ? CMD_REPLAY : CMD_PLAY;
    it.song_id    = slot;
    it.use_custom = ($urandom_range(0, 3) == 0);
    if (it.use_custom) begin
      it.tempo_bpm    = pick_tempo();
      it.repeat_count = 8'($urandom_range(0, 4));
      it.tail_beats   = 8'($urandom_range(0, 3));
    end
    issue(it, 1'b0, '0);
    repeat ($urandom_range(4, 30)) begin
      it = rand_item();
      if ($urandom_range(0, 9) != 0) it.cmd = CMD_TICK;
      issue(it, 1'b0, '0);
    end
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_tones.size() != 0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report(string msg);
    if (errors < PRINT_CAP) $display("tb: mismatch at result %0d: %s", n_checked, msg);
    errors++;
  endtask

  task automatic check_tone();
    tone_result_t want;
    if (expected_tones.size() == 0) begin
      report($sformatf("result with nothing expected (freq %0d song %0d)",
                       tone_ch.tone_freq, tone_ch.active_song));
      return;
    end
    want = expected_tones.pop_front();
    n_checked++;
    if (tone_ch.tone_on !== want.tone_on)
      report($sformatf("tone_on got %0d want %0d", tone_ch.tone_on, want.tone_on));
    if (tone_ch.tone_freq !== want.tone_freq)
      report($sformatf("tone_freq got %0d want %0d", tone_ch.tone_freq, want.tone_freq));
    if (tone_ch.playing !== want.playing)
      report($sformatf("playing got %0d want %0d", tone_ch.playing, want.playing));
    if (tone_ch.active_song !== want.active_song)
      report($sformatf("active_song got %0d want %0d", tone_ch.active_song,
                       want.active_song));
    if (tone_ch.beat_period_ms !== want.beat_period_ms)
      report($sformatf("beat_period_ms got %0d want %0d", tone_ch.beat_period_ms,
                       want.beat_period_ms));
  endtask

  // result side: check, then pick next ready; a hold request stalls it
  initial begin
    int stall;
    stall = 0;
    tone_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tone_ch.valid === 1'b1 && tone_ch.ready === 1'b1) check_tone();
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        tone_ch.ready <= 1'b0;
      end else begin
        tone_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_tones.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    bit        held;
    bit        paused;
    cmd_item_t it;
    dir_row_t  tick_row;
    held   = 1'b0;
    paused = 1'b0;
    rst    = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.cmd           = CMD_NOP;
    cmd_ch.song_id       = '0;
    cmd_ch.use_custom    = 1'b0;
    cmd_ch.tempo_bpm     = '0;
    cmd_ch.repeat_count  = '0;
    cmd_ch.tail_beats    = '0;
    cmd_ch.entry_address = '0;
    cmd_ch.entry_kind    = KIND_NOTE;
    cmd_ch.entry_freq    = '0;
    cmd_ch.entry_beats   = '0;
    cmd_ch.note_freq     = '0;
    hold_req      = 1'b0;
    errors        = 0;
    n_checked     = 0;
    items_done    = 0;
    n_fills       = 0;
    send_idle_pct = 29;
    recv_idle_pct = 82;
    seq           = '0;
    seq.tempo     = TEMPO_RESET;

    tick_row = op(CMD_TICK, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
                  16'd0);
    plan = '{
      pin(op(CMD_NOP, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
             16'd0), AT_RESET),
      pin(op(CMD_SPARE, 3'd7, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 10'h3FF, KIND_SPARE,
             16'hFFFF, 8'hFF, 16'hFFFF), AT_RESET),
      pin(op(CMD_TICK, 3'd7, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 10'h3FF, KIND_SPARE,
             16'hFFFF, 8'hFF, 16'hFFFF), AT_RESET),
      pin(op(CMD_PLAY_NOTE, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
             16'hFFFF), tone_result_t'{1'b1, 16'hFFFF, 1'b0, 3'd0, 16'd500}),
      pin(op(CMD_PLAY_NOTE, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
             16'd0), ZERO_NOTE),
      // song 1 wraps the top of memory; zero tempo, a zero-beat note,
      // and an unknown end kind
      pin(op(CMD_LOAD_HEADER, 3'd1, 1'b0, 16'd0, 8'd2, 8'd1, 10'd1022, KIND_NOTE, 16'd0,
             8'd0, 16'd0), ZERO_NOTE),
      pin(op(CMD_LOAD_ENTRY, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd1022, KIND_NOTE, 16'd440,
             8'd0, 16'd0), ZERO_NOTE),
      pin(op(CMD_LOAD_ENTRY, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd1023, KIND_NOTE,
             16'hFFFF, 8'd2, 16'd0), ZERO_NOTE),
      pin(op(CMD_LOAD_ENTRY, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_SPARE, 16'd0,
             8'd255, 16'd0), ZERO_NOTE),
      pin(op(CMD_PLAY, 3'd1, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
             16'd0), tone_result_t'{1'b1, 16'd0, 1'b1, 3'd0, 16'd500}),
      tick_row, tick_row, tick_row, tick_row, tick_row, tick_row, tick_row, tick_row,
      // song 2 starts on its end marker, so each repeat sounds that entry
      op(CMD_LOAD_HEADER, 3'd2, 1'b0, 16'd1, 8'd255, 8'd255, 10'd5, KIND_NOTE, 16'd0,
         8'd0, 16'd0),
      op(CMD_LOAD_ENTRY, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd5, KIND_END, 16'd1000, 8'd1,
         16'd0),
      op(CMD_LOAD_ENTRY, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd6, KIND_END_IDLE, 16'd2000,
         8'd1, 16'd0),
      op(CMD_REPLAY, 3'd2, 1'b1, 16'hFFFF, 8'd3, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
         16'd0),
      tick_row, tick_row,
      op(CMD_PLAY_NOTE, 3'd0, 1'b0, 16'd0, 8'd0, 8'd0, 10'd0, KIND_NOTE, 16'd0, 8'd0,
         16'd1234),
      tick_row
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(plan); i++) issue(plan[i].it, plan[i].pinned, plan[i].want);

    while (items_done < ITEM_TARGET) begin
      if (items_done < ITEM_TARGET / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 82;
      end else if (items_done < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // stall the result side while items keep coming
      if (!held && items_done >= 120) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && items_done >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 4) != 0) begin
        play_song_burst();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          it = rand_item();
          issue(it, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("tb: %0d ticks, %0d entry loads, %0d header loads, %0d play/replay, %0d notes,",
             n_cmd[CMD_TICK], n_cmd[CMD_LOAD_ENTRY], n_cmd[CMD_LOAD_HEADER],
             n_cmd[CMD_PLAY] + n_cmd[CMD_REPLAY], n_cmd[CMD_PLAY_NOTE]);
    $display("tb: %0d nop/unused, %0d fill loads; %0d results compared, %0d mismatches",
             n_cmd[CMD_NOP] + n_cmd[CMD_SPARE], n_fills, n_checked, errors);
    if (errors == 0 && expected_tones.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
